// ----- hw/rtl/tss_pkg.sv -----
// Shared types, signature table and sizing constants of the signature scanner.
package tss_pkg;

  localparam int SIG_COUNT = 8;
  localparam int SIG_IDX_W = 3;
  localparam int SIG_TBL_LEN = 10;
  localparam int MATCH_OFFSET_W = 32;
  localparam int DEF_OFFSET_BITS = 32;
  localparam int DEF_MAX_SIG_BYTES = 10;
  localparam int HIT_QUEUE_DEPTH = 4;

  typedef logic [7:0] byte_t;
  typedef logic [SIG_COUNT-1:0] hit_mask_t;
  typedef logic [SIG_IDX_W-1:0] sig_idx_t;

  // Signatures are stored first byte first and padded with zeros.
  localparam byte_t SIG_BYTES [SIG_COUNT][SIG_TBL_LEN] = '{
    '{8'h31, 8'hC0, 8'h50, 8'h68, 8'h2F, 8'h2F, 8'h73, 8'h68, 8'h00, 8'h00},
    '{8'h48, 8'h31, 8'hF6, 8'h56, 8'h48, 8'hBF, 8'h2F, 8'h62, 8'h00, 8'h00},
    '{8'hFC, 8'h48, 8'h83, 8'hE4, 8'hF0, 8'hE8, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h3C, 8'h3F, 8'h70, 8'h68, 8'h70, 8'h20, 8'h65, 8'h76, 8'h61, 8'h6C},
    '{8'h62, 8'h61, 8'h73, 8'h65, 8'h36, 8'h34, 8'h20, 8'h2D, 8'h64, 8'h00},
    '{8'h2F, 8'h64, 8'h65, 8'h76, 8'h2F, 8'h74, 8'h63, 8'h70, 8'h2F, 8'h00},
    '{8'h4C, 8'h44, 8'h5F, 8'h50, 8'h52, 8'h45, 8'h4C, 8'h4F, 8'h41, 8'h44},
    '{8'h70, 8'h74, 8'h72, 8'h61, 8'h63, 8'h65, 8'h00, 8'h00, 8'h00, 8'h00}
  };

  localparam int SIG_LEN [SIG_COUNT] = '{8, 8, 6, 10, 9, 9, 10, 6};

endpackage

// ----- hw/rtl/tss_front.sv -----
// Front end: byte window, stream position and parallel signature compare.
module tss_front #(
  parameter int OFFSET_BITS = tss_pkg::DEF_OFFSET_BITS,
  parameter int MAX_SIGNATURE_BYTES = tss_pkg::DEF_MAX_SIG_BYTES
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   accept_i,
  input  tss_pkg::byte_t         data_byte_i,
  input  logic                   final_byte_i,
  output tss_pkg::hit_mask_t     hit_mask_o,
  output logic [OFFSET_BITS-1:0] position_o
);
  import tss_pkg::*;

  localparam int HistDepth = MAX_SIGNATURE_BYTES - 1;

  byte_t                  hist_q [HistDepth];
  logic [OFFSET_BITS-1:0] pos_q;
  byte_t                  win [MAX_SIGNATURE_BYTES];
  hit_mask_t              hit;

  always_comb begin
    win[0] = data_byte_i;
    for (int k = 1; k < MAX_SIGNATURE_BYTES; k++) begin
      win[k] = hist_q[k-1];
    end
  end

  // A signature of length L ends here when the newest L bytes match it and
  // at least L bytes have arrived since the last clear.
  always_comb begin
    for (int s = 0; s < SIG_COUNT; s++) begin
      hit[s] = (pos_q >= OFFSET_BITS'(SIG_LEN[s] - 1));
      for (int i = 0; i < SIG_TBL_LEN; i++) begin
        if (i < SIG_LEN[s]) begin
          hit[s] = hit[s] & (SIG_BYTES[s][i] == win[SIG_LEN[s] - 1 - i]);
        end
      end
    end
  end

  assign hit_mask_o = hit;
  assign position_o = pos_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      for (int k = 0; k < HistDepth; k++) begin
        hist_q[k] <= '0;
      end
    end else if (accept_i) begin
      if (final_byte_i) begin
        pos_q <= '0;
        for (int k = 0; k < HistDepth; k++) begin
          hist_q[k] <= '0;
        end
      end else begin
        if (pos_q != '1) begin
          pos_q <= pos_q + OFFSET_BITS'(1);
        end
        hist_q[0] <= data_byte_i;
        for (int k = 1; k < HistDepth; k++) begin
          hist_q[k] <= hist_q[k-1];
        end
      end
    end
  end

endmodule

// ----- hw/rtl/tss_queue.sv -----
// Small first-in first-out queue of hit records between front and back end.
module tss_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = tss_pkg::HIT_QUEUE_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             full_o,
  output logic             empty_o
);
  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wptr_q, rptr_q;
  logic [CntW-1:0]  cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= (wptr_q == PtrW'(DEPTH - 1)) ? '0 : wptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == PtrW'(DEPTH - 1)) ? '0 : rptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

// ----- hw/rtl/tss_back.sv -----
// Back end: turns one hit record into results in ascending signature order.
module tss_back #(
  parameter int OFFSET_BITS = tss_pkg::DEF_OFFSET_BITS
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                head_valid_i,
  input  tss_pkg::hit_mask_t                  head_mask_i,
  input  logic [OFFSET_BITS-1:0]              head_pos_i,
  output logic                                head_pop_o,
  input  logic                                pop,
  output logic                                empty,
  output tss_pkg::sig_idx_t                   signature_index_o,
  output logic [tss_pkg::MATCH_OFFSET_W-1:0]  match_offset_o,
  output logic                                last_of_run_o
);
  import tss_pkg::*;

  logic                      out_valid_q;
  sig_idx_t                  idx_q;
  logic [MATCH_OFFSET_W-1:0] offset_q;
  logic                      last_q;
  hit_mask_t                 sent_q;

  hit_mask_t                 remaining, rest;
  sig_idx_t                  next_idx;
  logic [OFFSET_BITS-1:0]    start;
  logic                      load;

  // Lowest set bit wins.
  always_comb begin
    remaining = head_mask_i & ~sent_q;
    next_idx  = '0;
    for (int s = SIG_COUNT - 1; s >= 0; s--) begin
      if (remaining[s]) begin
        next_idx = SIG_IDX_W'(s);
      end
    end
    rest = remaining & ~(hit_mask_t'(1) << next_idx);
    start = head_pos_i - OFFSET_BITS'(SIG_LEN[next_idx] - 1);
  end

  assign load       = !out_valid_q || pop;
  assign head_pop_o = load && head_valid_i && (rest == '0);

  always_ff @(posedge clk_i) begin
    if (load && head_valid_i) begin
      idx_q    <= next_idx;
      offset_q <= MATCH_OFFSET_W'(start);
      last_q   <= (rest == '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      sent_q      <= '0;
    end else if (load) begin
      out_valid_q <= head_valid_i;
      if (head_valid_i) begin
        sent_q <= (rest == '0) ? '0 : (sent_q | (hit_mask_t'(1) << next_idx));
      end
    end
  end

  assign empty             = !out_valid_q;
  assign signature_index_o = idx_q;
  assign match_offset_o    = offset_q;
  assign last_of_run_o     = last_q;

endmodule

// ----- hw/rtl/threat_signature_scanner_top.sv -----
// A result is written into the hit queue when its byte is accepted and is then loaded into
// the result register, which drives the result ports.
// Throughput: one byte per cycle is accepted while the four-entry hit queue has room;
// results leave one per cycle while pop is high; a byte with n hits gives n results.
// Bytes without hits never enter the hit queue.
// Reset clears the byte history, the position count, the queue and the result valid flag.
module threat_signature_scanner_top #(
  parameter int OFFSET_BITS = tss_pkg::DEF_OFFSET_BITS,
  parameter int MAX_SIGNATURE_BYTES = tss_pkg::DEF_MAX_SIG_BYTES
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               push,
  output logic                               full,
  input  tss_pkg::byte_t                     data_byte_i,
  input  logic                               final_byte_i,
  output logic                               empty,
  input  logic                               pop,
  output tss_pkg::sig_idx_t                  signature_index_o,
  output logic [tss_pkg::MATCH_OFFSET_W-1:0] match_offset_o,
  output logic                               last_of_run_o
);
  import tss_pkg::*;

  localparam int RecW = SIG_COUNT + OFFSET_BITS;

  logic                   accept;
  hit_mask_t              hit_mask;
  logic [OFFSET_BITS-1:0] position;
  logic [RecW-1:0]        head_rec;
  logic                   q_full, q_empty, head_pop;

  assign full   = q_full;
  assign accept = push && !q_full;

  tss_front #(
    .OFFSET_BITS        (OFFSET_BITS),
    .MAX_SIGNATURE_BYTES(MAX_SIGNATURE_BYTES)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .data_byte_i (data_byte_i),
    .final_byte_i(final_byte_i),
    .hit_mask_o  (hit_mask),
    .position_o  (position)
  );

  tss_queue #(
    .WIDTH(RecW),
    .DEPTH(HIT_QUEUE_DEPTH)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (accept && (hit_mask != '0)),
    .wdata_i({hit_mask, position}),
    .pop_i  (head_pop),
    .rdata_o(head_rec),
    .full_o (q_full),
    .empty_o(q_empty)
  );

  tss_back #(
    .OFFSET_BITS(OFFSET_BITS)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .head_valid_i     (!q_empty),
    .head_mask_i      (head_rec[RecW-1:OFFSET_BITS]),
    .head_pos_i       (head_rec[OFFSET_BITS-1:0]),
    .head_pop_o       (head_pop),
    .pop              (pop),
    .empty            (empty),
    .signature_index_o(signature_index_o),
    .match_offset_o   (match_offset_o),
    .last_of_run_o    (last_of_run_o)
  );

endmodule

// ----- sim/tb_top.sv -----
// Self-checking testbench of the threat signature scanner: directed and random streams.
module tb_top;

  // A 16-bit position count is narrower than the result offset field.
  localparam int SCAN_OFFSET_BITS = 16;
  localparam int SIG_NUM = 8;
  localparam int SIG_MAX_LEN = 10;
  localparam int HISTORY_DEPTH = SIG_MAX_LEN - 1;
  localparam int CYCLE_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 10;

  typedef struct packed {
    tss_pkg::sig_idx_t idx;
    logic [31:0]       offset;
    logic              last;
  } hit_t;

  localparam tss_pkg::byte_t SIGNATURES [SIG_NUM][SIG_MAX_LEN] = '{
    '{8'h31, 8'hC0, 8'h50, 8'h68, 8'h2F, 8'h2F, 8'h73, 8'h68, 8'h00, 8'h00},
    '{8'h48, 8'h31, 8'hF6, 8'h56, 8'h48, 8'hBF, 8'h2F, 8'h62, 8'h00, 8'h00},
    '{8'hFC, 8'h48, 8'h83, 8'hE4, 8'hF0, 8'hE8, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h3C, 8'h3F, 8'h70, 8'h68, 8'h70, 8'h20, 8'h65, 8'h76, 8'h61, 8'h6C},
    '{8'h62, 8'h61, 8'h73, 8'h65, 8'h36, 8'h34, 8'h20, 8'h2D, 8'h64, 8'h00},
    '{8'h2F, 8'h64, 8'h65, 8'h76, 8'h2F, 8'h74, 8'h63, 8'h70, 8'h2F, 8'h00},
    '{8'h4C, 8'h44, 8'h5F, 8'h50, 8'h52, 8'h45, 8'h4C, 8'h4F, 8'h41, 8'h44},
    '{8'h70, 8'h74, 8'h72, 8'h61, 8'h63, 8'h65, 8'h00, 8'h00, 8'h00, 8'h00}
  };
  localparam int SIG_LENGTHS [SIG_NUM] = '{8, 8, 6, 10, 9, 9, 10, 6};

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic push = 1'b0;
  logic full;
  tss_pkg::byte_t data_byte = '0;
  logic final_byte = 1'b0;
  logic empty;
  logic pop = 1'b0;
  tss_pkg::sig_idx_t signature_index;
  logic [tss_pkg::MATCH_OFFSET_W-1:0] match_offset;
  logic last_of_run;

  // Scanner state as the predictor sees it.
  tss_pkg::byte_t scan_history [HISTORY_DEPTH] = '{default: '0};
  logic [SCAN_OFFSET_BITS-1:0] scan_pos = '0;
  hit_t pending_hits [$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int items_sent = 0;
  int mismatch_count = 0;
  int cycle_count = 0;

  threat_signature_scanner_top #(
    .OFFSET_BITS(SCAN_OFFSET_BITS)
  ) u_top (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .push              (push),
    .full              (full),
    .data_byte_i       (data_byte),
    .final_byte_i      (final_byte),
    .empty             (empty),
    .pop               (pop),
    .signature_index_o (signature_index),
    .match_offset_o    (match_offset),
    .last_of_run_o     (last_of_run)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Works out the hits that one accepted byte causes and updates the scan state.
  function automatic void scan_byte(input tss_pkg::byte_t value, input logic last);
    tss_pkg::byte_t window [SIG_MAX_LEN];
    hit_t hits [$];
    hit_t hit;
    logic [SCAN_OFFSET_BITS-1:0] start;
    logic found;
    window[0] = value;
    for (int k = 1; k < SIG_MAX_LEN; k++) window[k] = scan_history[k-1];
    for (int s = 0; s < SIG_NUM; s++) begin
      if (int'(scan_pos) >= SIG_LENGTHS[s] - 1) begin
        found = 1'b1;
        for (int i = 0; i < SIG_LENGTHS[s]; i++)
          if (SIGNATURES[s][i] != window[SIG_LENGTHS[s]-1-i]) found = 1'b0;
        if (found) begin
          start = scan_pos - SCAN_OFFSET_BITS'(SIG_LENGTHS[s] - 1);
          hit.idx = tss_pkg::sig_idx_t'(s);
          hit.offset = 32'(start);
          hit.last = 1'b0;
          hits.push_back(hit);
        end
      end
    end
    if (hits.size() > 0) hits[hits.size()-1].last = 1'b1;
    foreach (hits[i]) pending_hits.push_back(hits[i]);
    if (last) begin
      scan_history = '{default: '0};
      scan_pos = '0;
    end else begin
      for (int k = HISTORY_DEPTH - 1; k > 0; k--) scan_history[k] = scan_history[k-1];
      scan_history[0] = value;
      if (scan_pos != '1) scan_pos++;
    end
  endfunction

  task automatic check_hit();
    hit_t want;
    if (pending_hits.size() == 0) begin
      $display("%0t: unexpected result: index %0d offset %0d last %0b", $time,
               signature_index, match_offset, last_of_run);
      mismatch_count++;
    end else begin
      want = pending_hits.pop_front();
      if (signature_index !== want.idx) begin
        $display("%0t: signature_index expected %0d, got %0d", $time, want.idx,
                 signature_index);
        mismatch_count++;
      end
      if (match_offset !== want.offset) begin
        $display("%0t: match_offset expected %0d, got %0d", $time, want.offset,
                 match_offset);
        mismatch_count++;
      end
      if (last_of_run !== want.last) begin
        $display("%0t: last_of_run expected %0b, got %0b", $time, want.last, last_of_run);
        mismatch_count++;
      end
    end
  endtask

  // Result side: takes a transaction whenever pop and not empty, and stalls at random.
  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) check_hit();
    pop <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Push is left high after a transaction so that back-to-back bytes follow without a gap.
  task automatic send_byte(input tss_pkg::byte_t value, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      data_byte <= tss_pkg::byte_t'($urandom);
      final_byte <= 1'($urandom);
      @(posedge clk_i);
    end
    push <= 1'b1;
    data_byte <= value;
    final_byte <= last;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    scan_byte(value, last);
    items_sent++;
  endtask

  // Sends bytes first_pos up to end_pos-1 of a signature; the final flag goes on the last one if fin_last is set.
  task automatic send_sig(input int sig, input int first_pos, input int end_pos,
                          input logic fin_last);
    for (int i = first_pos; i < end_pos; i++)
      send_byte(SIGNATURES[sig][i], fin_last && (i == end_pos - 1));
  endtask

  task automatic test_byte_extremes();
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h80, 1'b1);
    send_byte(8'h7F, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'hFE, 1'b1);
  endtask

  // A signature cut by a final byte must not match across the clear.
  task automatic test_short_stream();
    send_sig(2, 0, 3, 1'b1);
    send_sig(2, 3, 6, 1'b0);
    send_sig(2, 0, 6, 1'b0);
    send_byte(8'h00, 1'b1);
    send_sig(7, 0, 6, 1'b0);
  endtask

  // Two overlapping matches, the second ending on a final byte, then a match at offset zero.
  task automatic test_overlap_and_final();
    send_sig(5, 0, 9, 1'b0);
    send_sig(5, 1, 9, 1'b1);
    send_sig(4, 0, 9, 1'b0);
  endtask

  task automatic test_random_traffic(input int n_items);
    int stop_at;
    int sig;
    int cut;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      sig = $urandom_range(SIG_NUM - 1);
      case ($urandom_range(9))
        0, 1, 2, 3: send_sig(sig, 0, SIG_LENGTHS[sig], $urandom_range(7) == 0);
        4: begin
          send_sig(5, 0, 9, 1'b0);
          send_sig(5, 1, 9, $urandom_range(3) == 0);
        end
        5, 6: begin
          cut = $urandom_range(SIG_LENGTHS[sig] - 1, 1);
          send_sig(sig, 0, cut, 1'b0);
          send_byte(tss_pkg::byte_t'($urandom), $urandom_range(15) == 0);
        end
        default: begin
          repeat ($urandom_range(4, 1))
            send_byte(tss_pkg::byte_t'($urandom), $urandom_range(15) == 0);
        end
      endcase
    end
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct = 19;
    recv_idle_pct = 50;
    test_byte_extremes();
    test_short_stream();
    test_overlap_and_final();
    test_random_traffic(135);

    send_idle_pct = 50;
    recv_idle_pct = 19;
    test_random_traffic(135);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(135);
    push <= 1'b0;

    while (pending_hits.size() != 0) @(posedge clk_i);
    // Any stray result would show up and be checked during the drain that follows.
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
